// ----- design/free_page_stack_allocator_macros.svh -----
// Assertion macros used by the allocator checker
`ifndef FREE_PAGE_STACK_ALLOCATOR_MACROS_SVH
`define FREE_PAGE_STACK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset
`define FPSA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset
`define FPSA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator check failed");

`endif

// ----- design/fpsa_pkg.sv -----
// Types, constants and command codes of the free page stack allocator
`default_nettype none
package fpsa_pkg;

	localparam int GLOBAL_DEPTH = 65536;
	localparam int LOCAL_DEPTH  = 255;
	localparam int REFILL_COUNT = 64;
	localparam int SPILL_COUNT  = 128;
	localparam int REFILL_LIM   = (REFILL_COUNT < LOCAL_DEPTH) ? REFILL_COUNT : LOCAL_DEPTH;
	localparam int SPILL_K      = (SPILL_COUNT < LOCAL_DEPTH) ? SPILL_COUNT : LOCAL_DEPTH;

	localparam int PAGE_W  = 20;
	localparam int COUNT_W = 17;
	localparam int BYTES_W = 32;
	localparam int NPG_W   = BYTES_W - 11;
	localparam int GAW     = $clog2(GLOBAL_DEPTH);
	localparam int LAW     = $clog2(LOCAL_DEPTH + 1);

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		KIND_SEED  = 2'd0,
		KIND_ALLOC = 2'd1,
		KIND_FREE  = 2'd2,
		KIND_RUN   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_PAGES = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_NO_RUN   = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [PAGE_W-1:0]  page_number;
		logic [BYTES_W-1:0] byte_size;
	} in_item_t;

	typedef struct packed {
		logic [PAGE_W-1:0]  result_page;
		logic [1:0]         status;
		logic [COUNT_W-1:0] allocated_pages;
		logic [COUNT_W-1:0] free_pages;
	} out_item_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,
		S_G_POP,
		S_REF_RD,
		S_REF_WR,
		S_L_RD,
		S_L_POP,
		S_SPL_RD,
		S_SPL_WR,
		S_LPUSH,
		S_SRCH_RD,
		S_SRCH_CHK,
		S_SH_INIT,
		S_SH_CHK,
		S_SH_RD,
		S_SH_WR,
		S_SH_DONE,
		S_FINISH
	} ctrl_state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_SEED,
		OP_GFREE,
		OP_GREAD,
		OP_GPOP,
		OP_REF_WR,
		OP_LREAD,
		OP_LPOP,
		OP_SPL_WR,
		OP_LPUSH,
		OP_SRCH_INIT,
		OP_SRCH_RD,
		OP_SRCH_CHK,
		OP_SH_INIT,
		OP_SH_RD,
		OP_SH_WR,
		OP_SH_DONE,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		logic    fail;
		status_t fail_status;
	} dp_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  cache_en;
		logic  seed_err;
		logic  free_err;
		logic  spill_err;
		logic  run_err;
		logic  gc_zero;
		logic  lc_zero;
		logic  lc_full;
		logic  refill_more;
		logic  spill_more;
		logic  chk_hit;
		logic  chk_last;
		logic  sh_more;
		logic  out_busy;
	} dp_stat_t;

endpackage
`default_nettype wire

// ----- design/fpsa_dp.sv -----
// Datapath: page stacks, counters, search and shift registers, result register
`default_nettype none
module fpsa_dp (
	input  wire                 clk,
	input  wire                 arst_n,
	input  fpsa_pkg::dp_cmd_t   cmd,
	output fpsa_pkg::dp_stat_t  stat,
	input  fpsa_pkg::in_item_t  in_data,
	input  wire                 cfg_we,
	input  wire                 cfg_wdata,
	input  wire                 out_stall,
	output logic                out_valid,
	output fpsa_pkg::out_item_t out_data
);
	import fpsa_pkg::*;

	logic [PAGE_W-1:0] gmem [GLOBAL_DEPTH];
	logic [PAGE_W-1:0] lmem [LOCAL_DEPTH];

	logic [COUNT_W-1:0] gc_q, total_q, alloc_q;
	logic [LAW-1:0]     lc_q;
	logic               ce_q;

	kind_t              kind_q;
	logic [PAGE_W-1:0]  page_q;
	logic [NPG_W-1:0]   n_q;
	logic [PAGE_W-1:0]  res_q;
	status_t            status_q;
	logic [LAW-1:0]     cnt_q;
	logic [GAW-1:0]     idx_q, t_q, dst_q;
	logic [COUNT_W-1:0] len_q, src_q;
	logic [PAGE_W-1:0]  prev_q, tval_q;
	logic [PAGE_W-1:0]  g_rd_q, l_rd_q;

	logic [BYTES_W:0]   bsum;
	logic [NPG_W-1:0]   n_calc;
	logic [COUNT_W-1:0] room, newlen, free_calc, alloc_amt, alloc_dec;
	logic [COUNT_W:0]   alloc_sum;
	logic [COUNT_W-1:0] alloc_inc;
	logic               cont;
	logic               g_we, l_we;
	logic [GAW-1:0]     g_waddr, g_raddr;
	logic [PAGE_W-1:0]  g_wdata, l_wdata;
	logic [LAW-1:0]     l_waddr, l_raddr;

	// Derive run length and status flags
	always_comb begin
		bsum   = {1'b0, in_data.byte_size} + (BYTES_W+1)'(4095);
		n_calc = bsum[BYTES_W:12];
		room   = (total_q > gc_q) ? total_q - gc_q : '0;
		cont   = (len_q != '0) && (({1'b0, prev_q} + (PAGE_W+1)'(1)) == {1'b0, g_rd_q});
		newlen = cont ? len_q + COUNT_W'(1) : COUNT_W'(1);

		stat.kind        = kind_q;
		stat.cache_en    = ce_q;
		stat.seed_err    = (total_q >= COUNT_W'(GLOBAL_DEPTH)) ||
		                   (gc_q >= COUNT_W'(GLOBAL_DEPTH));
		stat.free_err    = (gc_q >= total_q) || (gc_q >= COUNT_W'(GLOBAL_DEPTH));
		stat.spill_err   = room < COUNT_W'(SPILL_K);
		stat.run_err     = (n_q == '0) || (n_q > NPG_W'(gc_q));
		stat.gc_zero     = gc_q == '0;
		stat.lc_zero     = lc_q == '0;
		stat.lc_full     = lc_q >= LAW'(LOCAL_DEPTH);
		stat.refill_more = (({1'b0, lc_q} + (LAW+1)'(1)) < (LAW+1)'(REFILL_LIM)) &&
		                   (gc_q != '0);
		stat.spill_more  = ({1'b0, cnt_q} + (LAW+1)'(1)) < (LAW+1)'(SPILL_K);
		stat.chk_hit     = NPG_W'(newlen) >= n_q;
		stat.chk_last    = idx_q == '0;
		stat.sh_more     = src_q < gc_q;
		stat.out_busy    = out_valid && out_stall;
	end

	// Saturating allocation count updates
	always_comb begin
		alloc_amt = (cmd.op == OP_SH_DONE) ? COUNT_W'(n_q) : COUNT_W'(1);
		alloc_sum = {1'b0, alloc_q} + {1'b0, alloc_amt};
		alloc_inc = alloc_sum[COUNT_W] ? COUNT_MAX : alloc_sum[COUNT_W-1:0];
		alloc_dec = (alloc_q != '0) ? alloc_q - COUNT_W'(1) : alloc_q;
		free_calc = (total_q > alloc_q) ? total_q - alloc_q : '0;
	end

	// Steer memory ports
	always_comb begin
		g_we    = 1'b0;
		g_waddr = gc_q[GAW-1:0];
		g_wdata = page_q;
		g_raddr = GAW'(gc_q - COUNT_W'(1));
		l_we    = 1'b0;
		l_waddr = lc_q;
		l_wdata = page_q;
		l_raddr = lc_q - LAW'(1);
		case (cmd.op)
			OP_SEED, OP_GFREE: g_we = 1'b1;
			OP_SPL_WR: begin
				g_we    = 1'b1;
				g_wdata = l_rd_q;
			end
			OP_SH_WR: begin
				g_we    = 1'b1;
				g_waddr = dst_q;
				g_wdata = g_rd_q;
			end
			OP_SRCH_RD: g_raddr = idx_q;
			OP_SH_RD:   g_raddr = src_q[GAW-1:0];
			OP_REF_WR: begin
				l_we    = 1'b1;
				l_wdata = g_rd_q;
			end
			OP_LPUSH: l_we = 1'b1;
			default: ;
		endcase
	end

	// Global stack memory
	always_ff @(posedge clk) begin
		if (g_we)
			gmem[g_waddr] <= g_wdata;
		g_rd_q <= gmem[g_raddr];
	end

	// Local cache memory
	always_ff @(posedge clk) begin
		if (l_we)
			lmem[l_waddr] <= l_wdata;
		l_rd_q <= lmem[l_raddr];
	end

	// Update counters, cache enable and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gc_q      <= '0;
			total_q   <= '0;
			alloc_q   <= '0;
			lc_q      <= '0;
			ce_q      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we)
				ce_q <= cfg_wdata;
			case (cmd.op)
				OP_SEED: begin
					gc_q    <= gc_q + COUNT_W'(1);
					total_q <= total_q + COUNT_W'(1);
				end
				OP_GFREE: begin
					gc_q    <= gc_q + COUNT_W'(1);
					alloc_q <= alloc_dec;
				end
				OP_GREAD:  gc_q <= gc_q - COUNT_W'(1);
				OP_GPOP, OP_LPOP: alloc_q <= alloc_inc;
				OP_REF_WR: lc_q <= lc_q + LAW'(1);
				OP_LREAD:  lc_q <= lc_q - LAW'(1);
				OP_SPL_WR: gc_q <= gc_q + COUNT_W'(1);
				OP_LPUSH: begin
					lc_q    <= lc_q + LAW'(1);
					alloc_q <= alloc_dec;
				end
				OP_SH_DONE: begin
					gc_q    <= gc_q - COUNT_W'(n_q);
					alloc_q <= alloc_inc;
				end
				default: ;
			endcase
			if (cmd.op == OP_EMIT)
				out_valid <= 1'b1;
			else if (out_valid && !out_stall)
				out_valid <= 1'b0;
		end
	end

	// Hold the transaction, search and shift state, and the result
	always_ff @(posedge clk) begin
		if (cmd.fail)
			status_q <= cmd.fail_status;
		case (cmd.op)
			OP_LOAD: begin
				kind_q   <= kind_t'(in_data.kind);
				page_q   <= in_data.page_number;
				n_q      <= n_calc;
				res_q    <= '0;
				status_q <= ST_OK;
				cnt_q    <= '0;
			end
			OP_GPOP:   res_q <= g_rd_q;
			OP_LPOP:   res_q <= l_rd_q;
			OP_SPL_WR: cnt_q <= cnt_q + LAW'(1);
			OP_SRCH_INIT: begin
				idx_q <= GAW'(gc_q - COUNT_W'(1));
				len_q <= '0;
			end
			OP_SRCH_CHK: begin
				len_q  <= newlen;
				prev_q <= g_rd_q;
				idx_q  <= idx_q - GAW'(1);
				if (!cont) begin
					t_q    <= idx_q;
					tval_q <= g_rd_q;
				end
			end
			OP_SH_INIT: begin
				src_q <= COUNT_W'(t_q) + COUNT_W'(1);
				dst_q <= GAW'(COUNT_W'(t_q) + COUNT_W'(1) - COUNT_W'(n_q));
				res_q <= tval_q;
			end
			OP_SH_RD: src_q <= src_q + COUNT_W'(1);
			OP_SH_WR: dst_q <= dst_q + GAW'(1);
			OP_EMIT: begin
				out_data.result_page     <= res_q;
				out_data.status          <= status_q;
				out_data.allocated_pages <= alloc_q;
				out_data.free_pages      <= free_calc;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ----- design/fpsa_ctrl.sv -----
// Controller: sequences each transaction through the datapath
`default_nettype none
module fpsa_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  fpsa_pkg::dp_stat_t stat,
	output fpsa_pkg::dp_cmd_t  cmd
);
	import fpsa_pkg::*;

	ctrl_state_t state_q, state_nx;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nx;
	end

	assign in_stall = state_q != S_IDLE;

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_nx = S_DECODE;
			S_DECODE: begin
				unique case (stat.kind)
					KIND_SEED: state_nx = S_FINISH;
					KIND_ALLOC: begin
						if (!stat.cache_en)
							state_nx = stat.gc_zero ? S_FINISH : S_G_POP;
						else if (!stat.lc_zero)
							state_nx = S_L_POP;
						else
							state_nx = stat.gc_zero ? S_FINISH : S_REF_WR;
					end
					KIND_FREE: begin
						if (!stat.cache_en || !stat.lc_full)
							state_nx = S_FINISH;
						else
							state_nx = stat.spill_err ? S_FINISH : S_SPL_WR;
					end
					KIND_RUN: state_nx = stat.run_err ? S_FINISH : S_SRCH_RD;
					default: state_nx = S_FINISH;
				endcase
			end
			S_G_POP:    state_nx = S_FINISH;
			S_REF_RD:   state_nx = S_REF_WR;
			S_REF_WR:   state_nx = stat.refill_more ? S_REF_RD : S_L_RD;
			S_L_RD:     state_nx = S_L_POP;
			S_L_POP:    state_nx = S_FINISH;
			S_SPL_RD:   state_nx = S_SPL_WR;
			S_SPL_WR:   state_nx = stat.spill_more ? S_SPL_RD : S_LPUSH;
			S_LPUSH:    state_nx = S_FINISH;
			S_SRCH_RD:  state_nx = S_SRCH_CHK;
			S_SRCH_CHK: begin
				if (stat.chk_hit)
					state_nx = S_SH_INIT;
				else if (stat.chk_last)
					state_nx = S_FINISH;
				else
					state_nx = S_SRCH_RD;
			end
			S_SH_INIT:  state_nx = S_SH_CHK;
			S_SH_CHK:   state_nx = stat.sh_more ? S_SH_RD : S_SH_DONE;
			S_SH_RD:    state_nx = S_SH_WR;
			S_SH_WR:    state_nx = S_SH_CHK;
			S_SH_DONE:  state_nx = S_FINISH;
			S_FINISH:   if (!stat.out_busy) state_nx = S_IDLE;
			default:    state_nx = S_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd.op          = OP_NONE;
		cmd.fail        = 1'b0;
		cmd.fail_status = ST_OK;
		unique case (state_q)
			S_IDLE: if (in_valid) cmd.op = OP_LOAD;
			S_DECODE: begin
				unique case (stat.kind)
					KIND_SEED: begin
						if (stat.seed_err) begin
							cmd.fail        = 1'b1;
							cmd.fail_status = ST_OVERFLOW;
						end else begin
							cmd.op = OP_SEED;
						end
					end
					KIND_ALLOC: begin
						if (stat.cache_en && !stat.lc_zero) begin
							cmd.op = OP_LREAD;
						end else if (stat.gc_zero) begin
							cmd.fail        = 1'b1;
							cmd.fail_status = ST_NO_PAGES;
						end else begin
							cmd.op = OP_GREAD;
						end
					end
					KIND_FREE: begin
						if (!stat.cache_en) begin
							if (stat.free_err) begin
								cmd.fail        = 1'b1;
								cmd.fail_status = ST_OVERFLOW;
							end else begin
								cmd.op = OP_GFREE;
							end
						end else if (!stat.lc_full) begin
							cmd.op = OP_LPUSH;
						end else if (stat.spill_err) begin
							cmd.fail        = 1'b1;
							cmd.fail_status = ST_OVERFLOW;
						end else begin
							cmd.op = OP_LREAD;
						end
					end
					KIND_RUN: begin
						if (stat.run_err) begin
							cmd.fail        = 1'b1;
							cmd.fail_status = ST_NO_RUN;
						end else begin
							cmd.op = OP_SRCH_INIT;
						end
					end
					default: ;
				endcase
			end
			S_G_POP:   cmd.op = OP_GPOP;
			S_REF_RD:  cmd.op = OP_GREAD;
			S_REF_WR:  cmd.op = OP_REF_WR;
			S_L_RD:    cmd.op = OP_LREAD;
			S_L_POP:   cmd.op = OP_LPOP;
			S_SPL_RD:  cmd.op = OP_LREAD;
			S_SPL_WR:  cmd.op = OP_SPL_WR;
			S_LPUSH:   cmd.op = OP_LPUSH;
			S_SRCH_RD: cmd.op = OP_SRCH_RD;
			S_SRCH_CHK: begin
				cmd.op = OP_SRCH_CHK;
				if (!stat.chk_hit && stat.chk_last) begin
					cmd.fail        = 1'b1;
					cmd.fail_status = ST_NO_RUN;
				end
			end
			S_SH_INIT: cmd.op = OP_SH_INIT;
			S_SH_CHK:  cmd.op = OP_NONE;
			S_SH_RD:   cmd.op = OP_SH_RD;
			S_SH_WR:   cmd.op = OP_SH_WR;
			S_SH_DONE: cmd.op = OP_SH_DONE;
			S_FINISH:  if (!stat.out_busy) cmd.op = OP_EMIT;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ----- design/free_page_stack_allocator.sv -----
// Top level of the free page stack allocator
// One transaction at a time. Each is accepted, decoded and completed with a
// result; a plain seed, direct free or cached push needs no further step, a
// single pop from either stack reads and then pops. A cache refill moves up to
// 64 pages from the global stack to the local cache, a spill moves 128 pages
// back. A run allocation scans stack entries from the top, then shifts the
// entries above the run down. Each stack memory has a registered read: an
// entry is read in one cycle and written or compared in the next. The next
// transaction is accepted while a finished result waits.
`default_nettype none
module free_page_stack_allocator (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  fpsa_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  wire                 out_stall,
	output fpsa_pkg::out_item_t out_data,
	input  wire                 cfg_we,
	input  wire                 cfg_wdata
);
	import fpsa_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequence transactions
	fpsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Stacks, counters and result register
	fpsa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// ----- design/fpsa_checker.sv -----
// Port checker for the free page stack allocator, bound to the top level
`default_nettype none
`include "free_page_stack_allocator_macros.svh"
module fpsa_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 in_valid,
	input wire                 in_stall,
	input wire                 out_valid,
	input wire                 out_stall,
	input fpsa_pkg::out_item_t out_data
);
	import fpsa_pkg::*;

	// Hold a stalled result
	`FPSA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`FPSA_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data))
	// Failed transactions return no page
	`FPSA_ASSERT_NOW(a_err_page, out_valid && (out_data.status != ST_OK), out_data.result_page == '0)
	// Take one transaction at a time
	`FPSA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule

bind free_page_stack_allocator fpsa_checker u_fpsa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
`default_nettype wire
